/* sv/mms_pkg.sv */
// Shared types, constants and the note-splitting helper function of the melody sequencer.
`default_nettype none

package mms_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SLOT,
    ST_GROUP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [9:0]  mem_address;
    logic [7:0]  mem_byte;
    logic [1:0]  slot;
    logic [9:0]  tempo_value;
    logic [7:0]  repeat_limit;
    logic [15:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [4:0] octave;
    logic [3:0] pitch_class;
  } split_t;

  localparam logic [7:0]  END_MARK    = 8'h7F;
  localparam logic [8:0]  CHORD_LIMIT = 9'd256;
  localparam logic [12:0] GROUP_LIMIT = 13'd4096;

  // Quotient by 12 through the reciprocal 171/2048, exact for all byte values.
  function automatic split_t split_note(input logic [7:0] v);
    logic [18:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    split_t      res;
    p = {11'd0, v} * 19'd171;
    q = p[15:11];
    r = v - ({3'd0, q} * 8'd12);
    res.octave = q;
    res.pitch_class = r[3:0];
    return res;
  endfunction

endpackage

`default_nettype wire

/* sv/mms_front.sv */
// Command front end: accepts transfers and queues them for the engine.
`default_nettype none

module mms_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             cmd_valid,
  output logic            cmd_stall,
  input  mms_pkg::item_t  in_item,
  input  wire             pop,
  output logic            q_valid,
  output mms_pkg::item_t  q_item
);
  import mms_pkg::*;

  item_t      entry [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (count != 2'd0);
  assign take      = pop && q_valid;
  assign q_item    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !take) begin
        count <= count + 2'd1;
      end else if (take && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

/* sv/mms_back.sv */
// Sequencer engine: melody memory, track state and the note walk.
`default_nettype none

module mms_back #(
  parameter int TRACK_SLOTS        = 4,
  parameter int MELODY_BYTES       = 1024,
  parameter int MAX_NOTES_PER_STEP = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             q_valid,
  input  mms_pkg::item_t  q_item,
  output logic            pop,
  output logic            note_valid,
  input  wire             note_stall,
  output logic [1:0]      note_track,
  output logic [3:0]      pitch_class,
  output logic [4:0]      octave,
  output logic [17:0]     note_length,
  output logic            last_note
);
  import mms_pkg::*;

  localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int AW = $clog2(MELODY_BYTES);
  localparam int WW = (AW > 10) ? AW : 10;
  localparam logic [AW:0] MB_A = (AW + 1)'(MELODY_BYTES);
  localparam logic [WW:0] MB_W = (WW + 1)'(MELODY_BYTES);
  localparam logic [6:0]  MAXN = 7'(MAX_NOTES_PER_STEP);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TRACK_SLOTS - 1);

  logic [7:0] mem [MELODY_BYTES];
  logic [7:0] rd_data;
  logic       mem_we;
  logic [AW-1:0] mem_ra;
  logic [AW:0]   ra_sum;
  logic [AW:0]   p3_sum;
  logic [AW-1:0] p3;
  logic [1:0]    ra_off;

  logic          valid [TRACK_SLOTS];
  logic [AW-1:0] base  [TRACK_SLOTS];
  logic [9:0]    tempo [TRACK_SLOTS];
  logic [7:0]    rep   [TRACK_SLOTS];
  logic [AW-1:0] ptr   [TRACK_SLOTS];
  logic [31:0]   acc   [TRACK_SLOTS];
  logic [17:0]   glen  [TRACK_SLOTS];
  logic [7:0]    loops [TRACK_SLOTS];

  state_t        state;
  state_t        state_next;
  item_t         cur;
  logic [WW-1:0] wa;
  logic [SW-1:0] s;
  logic [6:0]    n;
  logic [12:0]   groups;
  logic [8:0]    ev;
  logic [7:0]    st_r;
  logic [7:0]    note_r;
  logic [17:0]   prod;
  logic          pv;
  logic [1:0]    pend_track;
  split_t        pend_split;
  logic [17:0]   pend_len;

  logic [4:0]    slot_w;
  logic [SW-1:0] slot_idx;
  logic          slot_ok;
  logic          wa_ge;
  logic          used_up;
  logic          group_go;
  logic          grp_end;
  logic          want;
  logic          out_free;
  logic          emit_wait;
  logic          out_load;
  logic [32:0]   acc_sum;
  logic [7:0]    note_v;

  assign slot_w   = {3'd0, cur.slot};
  assign slot_idx = slot_w[SW-1:0];
  assign slot_ok  = slot_w < 5'(TRACK_SLOTS);
  assign wa_ge    = {1'b0, wa} >= MB_W;
  assign used_up  = (rep[s] != 8'd0) && (loops[s] >= rep[s]);
  assign group_go = (acc[s] > {14'd0, glen[s]}) && (n < MAXN) && (groups < GROUP_LIMIT);
  assign grp_end  = (ev != 9'd0) && (!rd_data[7] || ev == CHORD_LIMIT);
  assign want     = (note_r != 8'd0) && (n < MAXN);
  assign out_free = !note_valid || !note_stall;
  assign emit_wait = want && pv && !out_free;
  assign out_load = ((state == ST_EMIT) && !emit_wait && want && pv) ||
                    ((state == ST_FLUSH) && pv && out_free);
  assign acc_sum  = {1'b0, acc[s]} + {17'd0, cur.elapsed};
  assign note_v   = note_r - 8'd1;

  assign ra_sum = {1'b0, ptr[s]} + {{(AW - 1){1'b0}}, ra_off};
  assign mem_ra = (ra_sum >= MB_A) ? AW'(ra_sum - MB_A) : ra_sum[AW-1:0];
  assign p3_sum = {1'b0, ptr[s]} + (AW + 1)'(3);
  assign p3     = (p3_sum >= MB_A) ? AW'(p3_sum - MB_A) : p3_sum[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.command)
            CMD_LOAD, CMD_SET: state_next = ST_WRAP;
            CMD_REMOVE:        state_next = ST_IDLE;
            CMD_ADVANCE:       state_next = ST_SLOT;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_WRAP: begin
        if (!wa_ge) begin
          state_next = ST_IDLE;
        end
      end
      ST_SLOT: begin
        if (valid[s] && !used_up) begin
          state_next = ST_GROUP;
        end else if (s == LAST_SLOT) begin
          state_next = ST_FLUSH;
        end
      end
      ST_GROUP: begin
        if (group_go) begin
          state_next = ST_RD0;
        end else if (s == LAST_SLOT) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_SLOT;
        end
      end
      ST_RD0: state_next = ST_RD1;
      ST_RD1: state_next = grp_end ? ST_GROUP : ST_RD2;
      ST_RD2: state_next = ST_RD3;
      ST_RD3: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!emit_wait) begin
          state_next = ST_RD0;
        end
      end
      ST_FLUSH: begin
        if (!pv || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop    = (state == ST_IDLE) && q_valid;
    mem_we = (state == ST_WRAP) && !wa_ge && (cur.command == CMD_LOAD);
    unique case (state)
      ST_RD1:  ra_off = 2'd1;
      ST_RD2:  ra_off = 2'd2;
      default: ra_off = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa[AW-1:0]] <= cur.mem_byte;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      note_valid <= 1'b0;
      pv         <= 1'b0;
      for (int i = 0; i < TRACK_SLOTS; i++) begin
        valid[i] <= 1'b0;
        base[i]  <= '0;
        tempo[i] <= '0;
        rep[i]   <= '0;
        ptr[i]   <= '0;
        acc[i]   <= '0;
        glen[i]  <= '0;
        loops[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        note_valid <= 1'b1;
      end else if (note_valid && !note_stall) begin
        note_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            wa  <= WW'(q_item.mem_address);
            s   <= '0;
            n   <= '0;
            if (q_item.command == CMD_REMOVE &&
                {3'd0, q_item.slot} < 5'(TRACK_SLOTS)) begin
              valid[SW'({3'd0, q_item.slot})] <= 1'b0;
            end
          end
        end
        ST_WRAP: begin
          if (wa_ge) begin
            wa <= WW'({1'b0, wa} - MB_W);
          end else if (cur.command == CMD_SET && slot_ok) begin
            valid[slot_idx] <= 1'b1;
            base[slot_idx]  <= wa[AW-1:0];
            ptr[slot_idx]   <= wa[AW-1:0];
            tempo[slot_idx] <= cur.tempo_value;
            rep[slot_idx]   <= cur.repeat_limit;
            acc[slot_idx]   <= '0;
            glen[slot_idx]  <= '0;
            loops[slot_idx] <= '0;
          end
        end
        ST_SLOT: begin
          groups <= '0;
          if (valid[s] && used_up) begin
            valid[s] <= 1'b0;
          end
          if (valid[s] && !used_up) begin
            acc[s] <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
          end else if (s != LAST_SLOT) begin
            s <= s + SW'(1);
          end
        end
        ST_GROUP: begin
          ev <= '0;
          if (group_go) begin
            groups <= groups + 13'd1;
          end else if (s != LAST_SLOT) begin
            s <= s + SW'(1);
          end
        end
        ST_RD1: begin
          st_r <= rd_data;
          if (grp_end) begin
            if (rd_data == END_MARK) begin
              if (loops[s] != 8'hFF) begin
                loops[s] <= loops[s] + 8'd1;
              end
              ptr[s] <= base[s];
            end
            acc[s] <= acc[s] - {14'd0, glen[s]};
          end
        end
        ST_RD2: note_r <= rd_data;
        ST_RD3: prod <= 18'(rd_data) * 18'(tempo[s]);
        ST_EMIT: begin
          if (!emit_wait) begin
            if (ev == 9'd0) begin
              glen[s] <= prod;
            end
            if (want) begin
              if (pv) begin
                note_track  <= pend_track;
                pitch_class <= pend_split.pitch_class;
                octave      <= pend_split.octave;
                note_length <= pend_len;
                last_note   <= 1'b0;
              end
              pv         <= 1'b1;
              pend_track <= 2'(s);
              pend_split <= split_note(note_v);
              pend_len   <= prod;
              n          <= n + 7'd1;
            end
            if (st_r != END_MARK) begin
              ptr[s] <= p3;
            end
            ev <= ev + 9'd1;
          end
        end
        ST_FLUSH: begin
          if (pv && out_free) begin
            note_track  <= pend_track;
            pitch_class <= pend_split.pitch_class;
            octave      <= pend_split.octave;
            note_length <= pend_len;
            last_note   <= 1'b1;
            pv          <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/multitrack_melody_sequencer_top.sv */
// Top level of the multi-track melody sequencer.
// Usage: commands arrive on the cmd channel (cmd_valid/cmd_stall); each transfer
// carries load, set track, remove track or advance time. Notes leave on the
// note channel (note_valid/note_stall), one transfer per note, last_note
// marking the final note of an advance.
// A two-entry queue takes commands while the engine works, so the sender is
// stalled only when both entries are full.
// Load and set pass through the address wrap state, which folds the address
// into the melody memory, and then finish; remove completes on acceptance.
// An advance walks every track slot, each melody event and chord group of
// an active track, and ends with a flush, all paced by the single read port
// of the melody memory (three byte reads per event).
// Each note is held one step so that the last one can be marked; the final
// note leaves after the walk ends.
// When the receiver stalls, the output register holds its note and the walk
// waits at the next note to emit. Reset clears all track slots and both
// channels; melody memory contents are kept and undefined until loaded.
`default_nettype none

module multitrack_melody_sequencer_top #(
  parameter int TRACK_SLOTS        = 4,
  parameter int MELODY_BYTES       = 1024,
  parameter int MAX_NOTES_PER_STEP = 64
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cmd_valid,
  output logic         cmd_stall,
  input  wire  [1:0]   command,
  input  wire  [9:0]   mem_address,
  input  wire  [7:0]   mem_byte,
  input  wire  [1:0]   slot,
  input  wire  [9:0]   tempo_value,
  input  wire  [7:0]   repeat_limit,
  input  wire  [15:0]  elapsed,
  output logic         note_valid,
  input  wire          note_stall,
  output logic [1:0]   note_track,
  output logic [3:0]   pitch_class,
  output logic [4:0]   octave,
  output logic [17:0]  note_length,
  output logic         last_note
);
  import mms_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  pop;

  assign in_item.command      = cmd_t'(command);
  assign in_item.mem_address  = mem_address;
  assign in_item.mem_byte     = mem_byte;
  assign in_item.slot         = slot;
  assign in_item.tempo_value  = tempo_value;
  assign in_item.repeat_limit = repeat_limit;
  assign in_item.elapsed      = elapsed;

  mms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .in_item   (in_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mms_back #(
    .TRACK_SLOTS        (TRACK_SLOTS),
    .MELODY_BYTES       (MELODY_BYTES),
    .MAX_NOTES_PER_STEP (MAX_NOTES_PER_STEP)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .note_valid  (note_valid),
    .note_stall  (note_stall),
    .note_track  (note_track),
    .pitch_class (pitch_class),
    .octave      (octave),
    .note_length (note_length),
    .last_note   (last_note)
  );

endmodule

`default_nettype wire

/* sv/mms_checker.sv */
// Port-level checks for the melody sequencer, bound to the top level.
`default_nettype none

module mms_checker (
  input wire        clk,
  input wire        rst,
  input wire        note_valid,
  input wire        note_stall,
  input wire [3:0]  pitch_class,
  input wire [4:0]  octave,
  input wire [17:0] note_length,
  input wire        last_note
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !note_valid)
    else $error("note channel valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    note_valid && note_stall |=> note_valid && $stable(pitch_class)
      && $stable(note_length) && $stable(last_note))
    else $error("stalled note changed");

  a_pitch: assert property (@(posedge clk) disable iff (rst)
    note_valid |-> pitch_class <= 4'd11)
    else $error("pitch class out of range");

  a_octave: assert property (@(posedge clk) disable iff (rst)
    note_valid |-> octave <= 5'd21)
    else $error("octave out of range");

endmodule

bind multitrack_melody_sequencer_top mms_checker u_mms_checker (
  .clk         (clk),
  .rst         (rst),
  .note_valid  (note_valid),
  .note_stall  (note_stall),
  .pitch_class (pitch_class),
  .octave      (octave),
  .note_length (note_length),
  .last_note   (last_note)
);

`default_nettype wire
